// File: rtl/gnss_power_supervisor_unit_macros.svh
// Assertion macros for the GNSS power supervisor.
`ifndef GNSS_POWER_SUPERVISOR_UNIT_MACROS_SVH
`define GNSS_POWER_SUPERVISOR_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define GPSU_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("gpsu assertion failed");
`define GPSU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("gpsu assertion failed");
`else
`define GPSU_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define GPSU_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/gpsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gpsu_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int POLL_W      = 16;
    localparam int LIMIT_W     = 8;
    localparam int FAIL_W      = 8;
    localparam int CMP_W       = (TIMER_WIDTH > POLL_W) ? TIMER_WIDTH : POLL_W;

    localparam logic [0:0] CFG_POLL_PERIOD = 1'b0;
    localparam logic [0:0] CFG_FAIL_LIMIT  = 1'b1;

    localparam logic [POLL_W-1:0]  POLL_PERIOD_RST = 16'd10;
    localparam logic [LIMIT_W-1:0] FAIL_LIMIT_RST  = 8'd2;

    localparam logic [7:0] HOST_RESTART = 8'd0;
    localparam logic [7:0] HOST_STOP    = 8'd1;

    localparam logic [1:0] GS_STOP   = 2'd0;
    localparam logic [1:0] GS_PRE    = 2'd1;
    localparam logic [1:0] GS_NORMAL = 2'd2;

    localparam logic [1:0] REQ_NONE    = 2'd0;
    localparam logic [1:0] REQ_RESTART = 2'd1;
    localparam logic [1:0] REQ_STOP    = 2'd2;

    localparam logic NOTE_STANDBY = 1'b0;
    localparam logic NOTE_NORMAL  = 1'b1;

    localparam logic RESP_RESTART = 1'b0;
    localparam logic RESP_STOP    = 1'b1;

    localparam logic [2:0] SC_IDLE    = 3'd0;
    localparam logic [2:0] SC_CYC     = 3'd1;
    localparam logic [2:0] SC_RWAIT   = 3'd2;
    localparam logic [2:0] SC_RESTART = 3'd3;
    localparam logic [2:0] SC_SWAIT   = 3'd4;
    localparam logic [2:0] SC_STOP    = 3'd5;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_CYC     = 6'b000010,
        ST_RWAIT   = 6'b000100,
        ST_RESTART = 6'b001000,
        ST_SWAIT   = 6'b010000,
        ST_STOP    = 6'b100000
    } state_t;

    typedef struct packed {
        logic       command;
        logic [7:0] gps_request;
        logic       peri_power_on;
        logic       monitor_level;
        logic       status_valid;
        logic [1:0] gps_status;
    } item_t;

    typedef struct packed {
        logic [2:0] state_now;
        logic       request_written;
        logic [1:0] request_code;
        logic       notify_written;
        logic       notify_code;
        logic       response_written;
        logic       response_code;
    } result_t;

    function automatic logic [2:0] state_code(input state_t st);
        logic [2:0] code;
        unique case (st)
            ST_IDLE:    code = SC_IDLE;
            ST_CYC:     code = SC_CYC;
            ST_RWAIT:   code = SC_RWAIT;
            ST_RESTART: code = SC_RESTART;
            ST_SWAIT:   code = SC_SWAIT;
            ST_STOP:    code = SC_STOP;
            default:    code = SC_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// File: rtl/gpsu_core.sv
`timescale 1ns / 1ps
`default_nettype none

module gpsu_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          step_en,
    input  wire gpsu_pkg::item_t               item,
    input  wire logic [gpsu_pkg::POLL_W-1:0]   poll_period,
    input  wire logic [gpsu_pkg::LIMIT_W-1:0]  fail_limit,
    output gpsu_pkg::result_t                  result
);

    gpsu_pkg::state_t                      state_reg, state_next;
    logic [gpsu_pkg::TIMER_WIDTH-1:0]      timer_reg, timer_next;
    logic [gpsu_pkg::FAIL_W-1:0]           fail_reg, fail_next;
    logic                                  pend_reg, pend_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gpsu_pkg::ST_IDLE;
            timer_reg <= '0;
            fail_reg  <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            timer_reg <= timer_next;
            fail_reg  <= fail_next;
            pend_reg  <= pend_next;
        end
    end

    always_comb begin
        logic [gpsu_pkg::TIMER_WIDTH-1:0] timer_tmp;
        logic [gpsu_pkg::FAIL_W-1:0]      fail_cur;
        logic [gpsu_pkg::FAIL_W-1:0]      fail_inc;
        logic                             poll_due;
        logic                             sts_pre;
        logic                             sts_normal;
        logic                             sts_stop;

        state_next = state_reg;
        timer_next = timer_reg;
        fail_next  = fail_reg;
        pend_next  = pend_reg;
        timer_tmp  = timer_reg;
        result     = '0;

        fail_cur   = item.peri_power_on ? fail_reg : '0;
        fail_inc   = (fail_cur == '1) ? fail_cur : fail_cur + 1'b1;
        poll_due   = gpsu_pkg::CMP_W'(timer_reg) >= gpsu_pkg::CMP_W'(poll_period);
        sts_pre    = item.status_valid && (item.gps_status == gpsu_pkg::GS_PRE);
        sts_normal = item.status_valid && (item.gps_status == gpsu_pkg::GS_NORMAL);
        sts_stop   = item.status_valid && (item.gps_status == gpsu_pkg::GS_STOP);

        if (step_en) begin
            if (item.command) begin
                if (item.gps_request == gpsu_pkg::HOST_RESTART) begin
                    pend_next              = 1'b1;
                    result.request_written = 1'b1;
                    result.request_code    = gpsu_pkg::REQ_RESTART;
                    state_next             = gpsu_pkg::ST_RWAIT;
                end else if (item.gps_request == gpsu_pkg::HOST_STOP) begin
                    pend_next              = 1'b1;
                    result.request_written = 1'b1;
                    result.request_code    = gpsu_pkg::REQ_STOP;
                    state_next             = gpsu_pkg::ST_SWAIT;
                end
            end else begin
                fail_next = fail_cur;
                unique case (state_reg)
                    gpsu_pkg::ST_IDLE: begin
                        if (sts_pre) begin
                            timer_tmp  = '0;
                            state_next = gpsu_pkg::ST_CYC;
                        end
                    end
                    gpsu_pkg::ST_CYC: begin
                        if (poll_due) begin
                            timer_tmp             = '0;
                            result.notify_written = 1'b1;
                            if (item.monitor_level) begin
                                result.notify_code = gpsu_pkg::NOTE_NORMAL;
                            end else begin
                                result.notify_code = gpsu_pkg::NOTE_STANDBY;
                                if (sts_normal) begin
                                    fail_next              = fail_inc;
                                    result.request_written = 1'b1;
                                    if (fail_inc >= fail_limit) begin
                                        result.request_code = gpsu_pkg::REQ_STOP;
                                        state_next          = gpsu_pkg::ST_SWAIT;
                                    end else begin
                                        result.request_code = gpsu_pkg::REQ_RESTART;
                                        state_next          = gpsu_pkg::ST_RWAIT;
                                    end
                                end
                            end
                        end
                    end
                    gpsu_pkg::ST_RWAIT: begin
                        if (sts_pre) begin
                            result.request_written = 1'b1;
                            result.request_code    = gpsu_pkg::REQ_NONE;
                            state_next             = gpsu_pkg::ST_RESTART;
                        end
                    end
                    gpsu_pkg::ST_RESTART: begin
                        if (item.status_valid && !sts_pre) begin
                            if (pend_reg) begin
                                pend_next               = 1'b0;
                                result.notify_written   = 1'b1;
                                result.notify_code      = gpsu_pkg::NOTE_STANDBY;
                                result.response_written = 1'b1;
                                result.response_code    = gpsu_pkg::RESP_RESTART;
                            end
                            timer_tmp  = '0;
                            state_next = gpsu_pkg::ST_CYC;
                        end
                    end
                    gpsu_pkg::ST_SWAIT: begin
                        if (sts_stop) begin
                            if (pend_reg) begin
                                pend_next               = 1'b0;
                                result.notify_written   = 1'b1;
                                result.notify_code      = gpsu_pkg::NOTE_STANDBY;
                                result.response_written = 1'b1;
                                result.response_code    = gpsu_pkg::RESP_STOP;
                            end
                            result.request_written = 1'b1;
                            result.request_code    = gpsu_pkg::REQ_NONE;
                            timer_tmp              = '0;
                            state_next             = gpsu_pkg::ST_STOP;
                        end
                    end
                    gpsu_pkg::ST_STOP: begin
                        if (poll_due) begin
                            timer_tmp             = '0;
                            result.notify_written = 1'b1;
                            result.notify_code    = gpsu_pkg::NOTE_STANDBY;
                        end
                    end
                    default: begin
                        state_next             = gpsu_pkg::ST_IDLE;
                        timer_tmp              = '0;
                        fail_next              = '0;
                        pend_next              = 1'b0;
                        result.request_written = 1'b1;
                        result.request_code    = gpsu_pkg::REQ_NONE;
                    end
                endcase
                timer_next = (timer_tmp == '1) ? timer_tmp : timer_tmp + 1'b1;
            end
        end

        result.state_now = gpsu_pkg::state_code(state_next);
    end

endmodule

`default_nettype wire

// File: rtl/gnss_power_supervisor_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Power supervisor for a GNSS receiver. Each input word is either a periodic tick that
// samples the supply, the power monitor and an optional fresh receiver status, or a host
// restart or stop request; every word yields exactly one result word with the new state
// and any request, notification or host reply issued. Words pass through an input
// register and a result register with the state update between them, so one word is
// taken per cycle and its result word is presented from the result register after the
// state update; a stalled result holds back further words only once both registers
// are full. Configuration writes take effect at once and are meant to be made while
// no word is in flight.

`include "gnss_power_supervisor_unit_macros.svh"

module gnss_power_supervisor_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // gps_request[7:0], peri_power_on[8], monitor_level[9], status_valid[10],
    // gps_status[12:11], zero fill [15:13]
    input  wire logic [15:0]                   s_tdata,
    // command[0]
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // state_now[2:0], request_written[3], request_code[5:4], notify_written[6],
    // notify_code[7], response_written[8], response_code[9], zero fill [15:10]
    output logic [15:0]                        m_tdata,
    input  wire logic                          cfg_we,
    input  wire logic [0:0]                    cfg_addr,
    input  wire logic [gpsu_pkg::POLL_W-1:0]   cfg_wdata
);

    logic                                  in_valid_reg, in_valid_next;
    gpsu_pkg::item_t                       in_item_reg;
    logic                                  out_valid_reg, out_valid_next;
    gpsu_pkg::result_t                     out_result_reg;
    logic [gpsu_pkg::POLL_W-1:0]           poll_period_reg;
    logic [gpsu_pkg::LIMIT_W-1:0]          fail_limit_reg;
    logic                                  advance;
    logic                                  step_en;
    logic                                  s_accept;
    gpsu_pkg::result_t                     step_result;

    assign advance  = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (step_en) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step_en) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            poll_period_reg <= gpsu_pkg::POLL_PERIOD_RST;
            fail_limit_reg  <= gpsu_pkg::FAIL_LIMIT_RST;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    gpsu_pkg::CFG_POLL_PERIOD: poll_period_reg <= cfg_wdata;
                    gpsu_pkg::CFG_FAIL_LIMIT:  fail_limit_reg  <= cfg_wdata[gpsu_pkg::LIMIT_W-1:0];
                    default:                   poll_period_reg <= poll_period_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.command       <= s_tuser;
            in_item_reg.gps_request   <= s_tdata[7:0];
            in_item_reg.peri_power_on <= s_tdata[8];
            in_item_reg.monitor_level <= s_tdata[9];
            in_item_reg.status_valid  <= s_tdata[10];
            in_item_reg.gps_status    <= s_tdata[12:11];
        end
        if (step_en) begin
            out_result_reg <= step_result;
        end
    end

    gpsu_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (step_en),
        .item        (in_item_reg),
        .poll_period (poll_period_reg),
        .fail_limit  (fail_limit_reg),
        .result      (step_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0,
                       out_result_reg.response_code,
                       out_result_reg.response_written,
                       out_result_reg.notify_code,
                       out_result_reg.notify_written,
                       out_result_reg.request_code,
                       out_result_reg.request_written,
                       out_result_reg.state_now};

    `GPSU_ASSERT_IMPLY(a_no_take_when_full, aclk, aresetn,
        in_valid_reg && out_valid_reg && !m_tready, !s_tready)
    `GPSU_ASSERT_IMPLY(a_reply_with_notify, aclk, aresetn,
        out_valid_reg && out_result_reg.response_written,
        out_result_reg.notify_written && (out_result_reg.notify_code == gpsu_pkg::NOTE_STANDBY))
    `GPSU_ASSERT_NEXT(a_step_fills_output, aclk, aresetn,
        step_en, out_valid_reg)

endmodule

`default_nettype wire

// File: tb/gpsu_watch.sv
`timescale 1ns / 1ps

// Watches both streams, mirrors the supervisor state and checks every result word.
module gpsu_watch
    import gpsu_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    input  wire logic [15:0]       s_tdata,
    input  wire logic              s_tuser,
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    input  wire logic [15:0]       m_tdata,
    input  wire logic              cfg_we,
    input  wire logic [0:0]        cfg_addr,
    input  wire logic [POLL_W-1:0] cfg_wdata,
    output int                     mismatches,
    output int                     outstanding
);

    logic [2:0]             phase;
    logic [TIMER_WIDTH-1:0] poll_timer;
    logic [FAIL_W-1:0]      fail_tally;
    logic                   reply_due;
    logic [POLL_W-1:0]      poll_setting;
    logic [LIMIT_W-1:0]     limit_setting;
    result_t                supervisor_outcomes[$];

    task automatic step_supervisor(input item_t w, output result_t r);
        r = '0;
        if (w.command) begin
            if (w.gps_request == HOST_RESTART) begin
                reply_due = 1'b1;
                r.request_written = 1'b1;
                r.request_code = REQ_RESTART;
                phase = SC_RWAIT;
            end else if (w.gps_request == HOST_STOP) begin
                reply_due = 1'b1;
                r.request_written = 1'b1;
                r.request_code = REQ_STOP;
                phase = SC_SWAIT;
            end
        end else begin
            if (!w.peri_power_on) begin
                fail_tally = '0;
            end
            case (phase)
                SC_IDLE: begin
                    if (w.status_valid && w.gps_status == GS_PRE) begin
                        poll_timer = '0;
                        phase = SC_CYC;
                    end
                end
                SC_CYC: begin
                    if (poll_timer >= poll_setting) begin
                        poll_timer = '0;
                        r.notify_written = 1'b1;
                        r.notify_code = w.monitor_level ? NOTE_NORMAL : NOTE_STANDBY;
                        if (!w.monitor_level && w.status_valid && w.gps_status == GS_NORMAL) begin
                            if (fail_tally != '1) begin
                                fail_tally = fail_tally + 1'b1;
                            end
                            r.request_written = 1'b1;
                            if (fail_tally >= limit_setting) begin
                                r.request_code = REQ_STOP;
                                phase = SC_SWAIT;
                            end else begin
                                r.request_code = REQ_RESTART;
                                phase = SC_RWAIT;
                            end
                        end
                    end
                end
                SC_RWAIT: begin
                    if (w.status_valid && w.gps_status == GS_PRE) begin
                        r.request_written = 1'b1;
                        r.request_code = REQ_NONE;
                        phase = SC_RESTART;
                    end
                end
                SC_RESTART: begin
                    if (w.status_valid && w.gps_status != GS_PRE) begin
                        if (reply_due) begin
                            reply_due = 1'b0;
                            r.notify_written = 1'b1;
                            r.notify_code = NOTE_STANDBY;
                            r.response_written = 1'b1;
                            r.response_code = RESP_RESTART;
                        end
                        poll_timer = '0;
                        phase = SC_CYC;
                    end
                end
                SC_SWAIT: begin
                    if (w.status_valid && w.gps_status == GS_STOP) begin
                        if (reply_due) begin
                            reply_due = 1'b0;
                            r.notify_written = 1'b1;
                            r.notify_code = NOTE_STANDBY;
                            r.response_written = 1'b1;
                            r.response_code = RESP_STOP;
                        end
                        r.request_written = 1'b1;
                        r.request_code = REQ_NONE;
                        poll_timer = '0;
                        phase = SC_STOP;
                    end
                end
                SC_STOP: begin
                    if (poll_timer >= poll_setting) begin
                        poll_timer = '0;
                        r.notify_written = 1'b1;
                        r.notify_code = NOTE_STANDBY;
                    end
                end
                default: begin
                    phase = SC_IDLE;
                    poll_timer = '0;
                    fail_tally = '0;
                    reply_due = 1'b0;
                    r.request_written = 1'b1;
                    r.request_code = REQ_NONE;
                end
            endcase
            if (poll_timer != '1) begin
                poll_timer = poll_timer + 1'b1;
            end
        end
        r.state_now = phase;
    endtask

    task automatic compare_field(input string name, input logic [2:0] want,
                                 input logic [2:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $realtime, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        item_t   word_in;
        result_t want;
        result_t got;
        int      delta;
        if (!aresetn) begin
            phase = SC_IDLE;
            poll_timer = '0;
            fail_tally = '0;
            reply_due = 1'b0;
            poll_setting = POLL_PERIOD_RST;
            limit_setting = FAIL_LIMIT_RST;
            supervisor_outcomes.delete();
            mismatches = 0;
            outstanding <= 0;
        end else begin
            delta = 0;
            if (cfg_we) begin
                if (cfg_addr == CFG_POLL_PERIOD) begin
                    poll_setting = cfg_wdata;
                end else begin
                    limit_setting = cfg_wdata[LIMIT_W-1:0];
                end
            end
            if (m_tvalid && m_tready) begin
                got.state_now        = m_tdata[2:0];
                got.request_written  = m_tdata[3];
                got.request_code     = m_tdata[5:4];
                got.notify_written   = m_tdata[6];
                got.notify_code      = m_tdata[7];
                got.response_written = m_tdata[8];
                got.response_code    = m_tdata[9];
                if (supervisor_outcomes.size() == 0) begin
                    $display("%0t: result word 0x%h with nothing expected", $realtime, m_tdata);
                    mismatches++;
                end else begin
                    want = supervisor_outcomes.pop_front();
                    delta = delta - 1;
                    compare_field("state_now", want.state_now, got.state_now);
                    compare_field("request_written", 3'(want.request_written),
                                  3'(got.request_written));
                    compare_field("request_code", 3'(want.request_code),
                                  3'(got.request_code));
                    compare_field("notify_written", 3'(want.notify_written),
                                  3'(got.notify_written));
                    compare_field("notify_code", 3'(want.notify_code),
                                  3'(got.notify_code));
                    compare_field("response_written", 3'(want.response_written),
                                  3'(got.response_written));
                    compare_field("response_code", 3'(want.response_code),
                                  3'(got.response_code));
                end
            end
            if (s_tvalid && s_tready) begin
                word_in.command       = s_tuser;
                word_in.gps_request   = s_tdata[7:0];
                word_in.peri_power_on = s_tdata[8];
                word_in.monitor_level = s_tdata[9];
                word_in.status_valid  = s_tdata[10];
                word_in.gps_status    = s_tdata[12:11];
                step_supervisor(word_in, want);
                supervisor_outcomes.push_back(want);
                delta = delta + 1;
            end
            outstanding <= outstanding + delta;
        end
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import gpsu_pkg::*;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idling_t;

    localparam int CYCLE_LIMIT = 400000;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [15:0]       s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [15:0]       m_tdata;
    logic              cfg_we;
    logic [0:0]        cfg_addr;
    logic [POLL_W-1:0] cfg_wdata;

    int     mismatch_count;
    int     words_in_flight;
    int     cycle_count = 0;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     hold_left;
    logic   hold_go;
    logic   hold_seen;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    gnss_power_supervisor_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    gpsu_watch watch (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatch_count),
        .outstanding (words_in_flight)
    );

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // The receiver holds off for a long stretch each time hold_go toggles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left <= 0;
            hold_seen <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_go != hold_seen) begin
            hold_seen <= hold_go;
            hold_left <= 80;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic item_t tick_word(input logic peri, input logic mon,
                                        input logic fresh, input logic [1:0] sts);
        item_t w;
        w.command       = 1'b0;
        w.gps_request   = 8'($urandom);
        w.peri_power_on = peri;
        w.monitor_level = mon;
        w.status_valid  = fresh;
        w.gps_status    = sts;
        return w;
    endfunction

    function automatic item_t host_word(input logic [7:0] code);
        item_t w;
        w = tick_word(1'($urandom), 1'($urandom), 1'($urandom), 2'($urandom));
        w.command     = 1'b1;
        w.gps_request = code;
        return w;
    endfunction

    function automatic item_t random_word();
        item_t w;
        w.command = ($urandom_range(99) < 10);
        case ($urandom_range(4))
            0, 1:    w.gps_request = HOST_RESTART;
            2, 3:    w.gps_request = HOST_STOP;
            default: w.gps_request = 8'($urandom);
        endcase
        w.peri_power_on = ($urandom_range(99) >= 8);
        w.monitor_level = 1'($urandom);
        w.status_valid  = ($urandom_range(99) < 75);
        w.gps_status    = 2'($urandom_range(3));
        return w;
    endfunction

    task automatic send_word(input item_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.command;
        s_tdata  <= {3'b000, w.gps_status, w.status_valid, w.monitor_level,
                     w.peri_power_on, w.gps_request};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_word(random_word());
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (words_in_flight != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_settings(input logic [POLL_W-1:0] poll,
                                  input logic [POLL_W-1:0] limit);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_POLL_PERIOD;
        cfg_wdata <= poll;
        @(posedge aclk);
        cfg_addr  <= CFG_FAIL_LIMIT;
        cfg_wdata <= limit;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_idling(input idling_t mode);
        send_idle_pct = (mode == IDLE_SEND) ? 60 : (mode == IDLE_BOTH) ? 28 : 0;
        recv_stall_pct <= (mode == IDLE_RECV) ? 60 : (mode == IDLE_BOTH) ? 28 : 0;
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_go        = 1'b0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed walk through each state with the reset settings.
        send_word(tick_word(1'b1, 1'b1, 1'b0, GS_PRE));
        send_word(host_word(8'hFF));
        send_word(tick_word(1'b1, 1'b1, 1'b1, GS_PRE));
        repeat (9) send_word(tick_word(1'b1, 1'b0, 1'b1, GS_NORMAL));
        send_word(tick_word(1'b1, 1'b0, 1'b1, GS_NORMAL));
        send_word(tick_word(1'b1, 1'b1, 1'b1, GS_PRE));
        send_word(tick_word(1'b1, 1'b1, 1'b1, GS_NORMAL));
        send_word(host_word(HOST_STOP));
        send_word(tick_word(1'b1, 1'b1, 1'b1, GS_STOP));
        send_word(host_word(HOST_RESTART));
        send_word(tick_word(1'b1, 1'b0, 1'b1, GS_PRE));
        send_word(tick_word(1'b1, 1'b0, 1'b1, 2'd3));
        send_word(tick_word(1'b0, 1'b0, 1'b0, GS_NORMAL));
        send_word(host_word(HOST_STOP));
        send_word(tick_word(1'b1, 1'b1, 1'b1, GS_PRE));
        send_word(tick_word(1'b1, 1'b1, 1'b1, GS_STOP));

        set_idling(IDLE_NONE);
        send_random(75);
        drain();

        write_settings(16'd0, 16'd0);
        set_idling(IDLE_SEND);
        send_random(75);
        drain();

        write_settings(16'd1, 16'd1);
        set_idling(IDLE_RECV);
        send_random(75);
        drain();

        write_settings(16'hFFFF, {8'($urandom), 8'hFF});
        set_idling(IDLE_BOTH);
        send_random(75);
        drain();

        // Long receiver hold-off while words keep coming, so the block backs up.
        write_settings(16'd4, 16'd3);
        set_idling(IDLE_NONE);
        hold_go <= ~hold_go;
        send_random(75);
        drain();

        // Drive the failure count into saturation through repeated restarts.
        write_settings(16'd0, {8'($urandom), 8'hFF});
        set_idling(idling_t'($urandom_range(3)));
        send_word(tick_word(1'b0, 1'b1, 1'b0, 2'($urandom)));
        send_word(host_word(HOST_RESTART));
        send_word(tick_word(1'b1, 1'($urandom), 1'b1, GS_PRE));
        send_word(tick_word(1'b1, 1'b1, 1'b1, GS_NORMAL));
        repeat (255) begin
            send_word(tick_word(1'b1, 1'b0, 1'b1, GS_NORMAL));
            send_word(tick_word(1'b1, 1'($urandom), 1'b1, GS_PRE));
            send_word(tick_word(1'b1, 1'($urandom), 1'b1, GS_NORMAL));
        end
        repeat (2) begin
            send_word(host_word(HOST_RESTART));
            send_word(tick_word(1'b1, 1'($urandom), 1'b1, GS_PRE));
            send_word(tick_word(1'b1, 1'b1, 1'b1, GS_NORMAL));
            send_word(tick_word(1'b1, 1'b0, 1'b1, GS_NORMAL));
        end
        drain();

        write_settings(16'($urandom_range(6)), 16'($urandom_range(4)));
        set_idling(idling_t'($urandom_range(3)));
        send_random(75);
        drain();

        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/gpsu_pkg.sv
rtl/gpsu_core.sv
rtl/gnss_power_supervisor_unit.sv
tb/gpsu_watch.sv
tb/tb_top.sv
